>>> hdl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

  // Default geometry of the bank.
  localparam int NumTimers = 64;
  localparam int TimeWidth = 32;

  // Field widths of the request and result items.
  localparam int IdWidth     = 6;
  localparam int PeriodWidth = 32;
  localparam int DeltaWidth  = 16;

  // Request operation codes. Codes 6 and 7 are ignored.
  typedef enum logic [2:0] {
    ModeAddFree = 3'd0,
    ModeAddId   = 3'd1,
    ModeRemove  = 3'd2,
    ModeSetEn   = 3'd3,
    ModeReadEn  = 3'd4,
    ModeTick    = 3'd5
  } mode_e;

  // One request.
  typedef struct packed {
    mode_e                  mode;
    logic [IdWidth-1:0]     timer_id;
    logic [PeriodWidth-1:0] period;
    logic                   enable_flag;
    logic [DeltaWidth-1:0]  delta;
  } req_t;

  // One result.
  typedef struct packed {
    logic [IdWidth-1:0] result_id;
    logic               ok;
    logic               status;
    logic               fired;
    logic               last;
  } res_t;

endpackage

>>> hdl/periodic_timer_bank.sv
// Top level of the periodic timer bank: request control, slot flags and tick scan.
//
// A request is taken on a rising edge with start_i high and busy_o low; busy_o
// stays high until the request is finished, so one request is worked at a time.
// Results leave on res_o, each valid for exactly one cycle while result_valid_o
// is high. The receiver cannot stall them; last marks the final result of a
// request.
// Remove, set enable, read enable and add at id are worked in the execute state
// after the request edge; a result, if any, shows in the cycle after that state.
// Add at first free walks the present flags one slot a cycle until a free slot
// or the last slot is reached; its result is registered.
// A tick reads the interval and last-firing memories one slot a cycle through
// their single read port, so it keeps busy_o high through scan, drain and flush.
// Each firing is held until the next firing is found or the scan ends, so that
// the final one can carry last; a tick with no firing gives no result.
// Reset clears the present and enabled flags, the tick count and all control
// state. The memories are not cleared: the data of a slot is only used once an
// add has written it.
module periodic_timer_bank #(
  parameter int NUM_TIMERS = ptb_pkg::NumTimers,
  parameter int TIME_WIDTH = ptb_pkg::TimeWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ptb_pkg::req_t req_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output ptb_pkg::res_t res_o
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW = TIME_WIDTH;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StFind,
    StScan,
    StDrain,
    StFlush
  } state_e;

  state_e                  state_q, state_d;
  ptb_pkg::req_t           req_q, req_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic                    chk_v_q, chk_v_d;
  logic [IW-1:0]           chk_idx_q, chk_idx_d;
  logic                    pend_v_q, pend_v_d;
  logic [IW-1:0]           pend_id_q, pend_id_d;
  logic [TW-1:0]           now_q, now_d;
  logic [NUM_TIMERS-1:0]   present_q, present_d;
  logic [NUM_TIMERS-1:0]   enabled_q, enabled_d;
  logic                    res_valid_q, res_valid_d;
  ptb_pkg::res_t           res_q, res_d;

  logic                    iv_we, lft_we;
  logic [IW-1:0]           wr_addr;
  logic [TW-1:0]           iv_wdata, lft_wdata;
  logic [TW-1:0]           iv_rdata, lft_rdata;
  logic                    in_range;
  logic [IW-1:0]           slot;
  logic [TW-1:0]           elapsed;
  logic                    fire;

  // Timer memories, read at the scan index.
  ptb_store #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (idx_q),
    .wr_addr_i  (wr_addr),
    .iv_we_i    (iv_we),
    .iv_wdata_i (iv_wdata),
    .lft_we_i   (lft_we),
    .lft_wdata_i(lft_wdata),
    .iv_rdata_o (iv_rdata),
    .lft_rdata_o(lft_rdata)
  );

  // Addressed slot of the held request.
  assign in_range = ({1'b0, req_q.timer_id} < (ptb_pkg::IdWidth + 1)'(NUM_TIMERS));
  assign slot     = req_q.timer_id[IW-1:0];

  // Firing test for the slot whose memory data came back this cycle.
  assign elapsed = now_q - lft_rdata;
  assign fire    = chk_v_q && present_q[chk_idx_q] && enabled_q[chk_idx_q]
                   && (elapsed > iv_rdata);

  // Next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    now_d       = now_q;
    present_d   = present_q;
    enabled_d   = enabled_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    iv_we       = 1'b0;
    lft_we      = 1'b0;
    wr_addr     = '0;
    iv_wdata    = TW'(req_q.period);
    lft_wdata   = now_q;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d    = req_i;
          idx_d    = '0;
          chk_v_d  = 1'b0;
          pend_v_d = 1'b0;
          case (req_i.mode)
            ptb_pkg::ModeAddFree: state_d = StFind;
            ptb_pkg::ModeTick: begin
              now_d   = now_q + TW'(req_i.delta);
              state_d = StScan;
            end
            default: state_d = StExec;
          endcase
        end
      end

      StExec: begin
        case (req_q.mode)
          ptb_pkg::ModeAddId: begin
            if (in_range) begin
              iv_we            = 1'b1;
              lft_we           = 1'b1;
              wr_addr          = slot;
              present_d[slot]  = 1'b1;
              enabled_d[slot]  = req_q.enable_flag;
            end
            res_valid_d     = 1'b1;
            res_d.result_id = req_q.timer_id;
            res_d.ok        = in_range;
            res_d.last      = 1'b1;
          end
          ptb_pkg::ModeRemove: begin
            if (in_range) begin
              present_d[slot] = 1'b0;
            end
          end
          ptb_pkg::ModeSetEn: begin
            if (in_range) begin
              // Enabling a disabled slot rearms it.
              if (!enabled_q[slot] && req_q.enable_flag) begin
                lft_we  = 1'b1;
                wr_addr = slot;
              end
              enabled_d[slot] = req_q.enable_flag;
            end
          end
          ptb_pkg::ModeReadEn: begin
            res_valid_d     = 1'b1;
            res_d.result_id = req_q.timer_id;
            res_d.status    = in_range && enabled_q[slot];
            res_d.last      = 1'b1;
          end
          default: ;
        endcase
        state_d = StIdle;
      end

      StFind: begin
        if (!present_q[idx_q]) begin
          iv_we            = 1'b1;
          lft_we           = 1'b1;
          wr_addr          = idx_q;
          present_d[idx_q] = 1'b1;
          enabled_d[idx_q] = req_q.enable_flag;
          res_valid_d      = 1'b1;
          res_d.result_id  = ptb_pkg::IdWidth'(idx_q);
          res_d.ok         = 1'b1;
          res_d.last       = 1'b1;
          state_d          = StIdle;
        end else if (idx_q == LastIdx) begin
          // Bank full.
          res_valid_d = 1'b1;
          res_d.last  = 1'b1;
          state_d     = StIdle;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      StScan, StDrain: begin
        // Rearm a firing slot and report the previous firing, if any.
        if (fire) begin
          lft_we    = 1'b1;
          wr_addr   = chk_idx_q;
          if (pend_v_q) begin
            res_valid_d     = 1'b1;
            res_d.result_id = ptb_pkg::IdWidth'(pend_id_q);
            res_d.fired     = 1'b1;
          end
          pend_v_d  = 1'b1;
          pend_id_d = chk_idx_q;
        end
        if (state_q == StScan) begin
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q;
          if (idx_q == LastIdx) begin
            state_d = StDrain;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          chk_v_d = 1'b0;
          state_d = StFlush;
        end
      end

      StFlush: begin
        // The firing still held is the final result of the tick.
        if (pend_v_q) begin
          res_valid_d     = 1'b1;
          res_d.result_id = ptb_pkg::IdWidth'(pend_id_q);
          res_d.fired     = 1'b1;
          res_d.last      = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  // State, flags, tick count and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_q       <= '0;
      idx_q       <= '0;
      chk_v_q     <= 1'b0;
      chk_idx_q   <= '0;
      pend_v_q    <= 1'b0;
      pend_id_q   <= '0;
      now_q       <= '0;
      present_q   <= '0;
      enabled_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      idx_q       <= idx_d;
      chk_v_q     <= chk_v_d;
      chk_idx_q   <= chk_idx_d;
      pend_v_q    <= pend_v_d;
      pend_id_q   <= pend_id_d;
      now_q       <= now_d;
      present_q   <= present_d;
      enabled_q   <= enabled_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  // An accepted request holds the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not make the block busy");

  // A firing report only leaves from the tick scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.fired |->
      ($past(state_q) == StScan || $past(state_q) == StDrain ||
       $past(state_q) == StFlush))
    else $error("firing reported outside a tick scan");

  // A rearm write during the scan never hits the slot being read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lft_we && state_q == StScan |-> wr_addr != idx_q)
    else $error("scan read and rearm write collide");

  // No firing is left pending once the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !pend_v_q)
    else $error("firing still pending while idle");

endmodule

>>> hdl/ptb_store.sv
// Interval and last-firing-time memories of the timer bank.
module ptb_store #(
  parameter int NUM_TIMERS = ptb_pkg::NumTimers,
  parameter int TIME_WIDTH = ptb_pkg::TimeWidth,
  localparam int AddrWidth = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                  clk_i,
  input  logic [AddrWidth-1:0]  rd_addr_i,
  input  logic [AddrWidth-1:0]  wr_addr_i,
  input  logic                  iv_we_i,
  input  logic [TIME_WIDTH-1:0] iv_wdata_i,
  input  logic                  lft_we_i,
  input  logic [TIME_WIDTH-1:0] lft_wdata_i,
  output logic [TIME_WIDTH-1:0] iv_rdata_o,
  output logic [TIME_WIDTH-1:0] lft_rdata_o
);

  logic [TIME_WIDTH-1:0] iv_mem  [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] lft_mem [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] iv_rdata_q;
  logic [TIME_WIDTH-1:0] lft_rdata_q;

  // Interval memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (iv_we_i) begin
      iv_mem[wr_addr_i] <= iv_wdata_i;
    end
    iv_rdata_q <= iv_mem[rd_addr_i];
  end

  // Last-firing-time memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (lft_we_i) begin
      lft_mem[wr_addr_i] <= lft_wdata_i;
    end
    lft_rdata_q <= lft_mem[rd_addr_i];
  end

  assign iv_rdata_o  = iv_rdata_q;
  assign lft_rdata_o = lft_rdata_q;

endmodule
